FILE: hdl/dfm_pkg.sv
// Shared types and constants for the double-precision fmod block.
package dfm_pkg;

	localparam int MAG_W = 54;
	localparam int EXP_W = 13;

	localparam logic [62:0] EXP_MASK  = {11'h7ff, 52'd0};
	localparam logic [63:0] QNAN_BITS = 64'h7ff8_0000_0000_0000;

	typedef enum logic [1:0] {
		CLS_WORK,
		CLS_NAN,
		CLS_PASS,
		CLS_ZERO
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t               kind;
		logic                    sign;
		logic signed [EXP_W-1:0] ex;
		logic signed [EXP_W-1:0] ey;
		logic [MAG_W-1:0]        mx;
		logic [MAG_W-1:0]        my;
	} cls_t;

	typedef enum logic [1:0] {
		OP_SHL,
		OP_SHR,
		OP_RED,
		OP_REDSHL
	} unit_op_t;

	typedef struct packed {
		logic ge;
		logic eq;
	} unit_flags_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UNPX,
		S_UNPY,
		S_DIV,
		S_NORM,
		S_DENORM,
		S_DONE
	} seq_state_t;

endpackage

FILE: hdl/dfm_classify.sv
// Operand decode: special-case detection and raw significand/exponent split.
module dfm_classify import dfm_pkg::*; (
	input  logic [63:0] dividend_bits,
	input  logic [63:0] divisor_bits,
	output cls_t        cls
);

	logic [62:0] ax;
	logic [62:0] ay;
	logic [10:0] bx;
	logic [10:0] by;

	assign ax = dividend_bits[62:0];
	assign ay = divisor_bits[62:0];
	assign bx = dividend_bits[62:52];
	assign by = divisor_bits[62:52];

	always_comb begin
		cls.sign = dividend_bits[63];
		if (ay == 63'd0 || ay > EXP_MASK || ax >= EXP_MASK) begin
			cls.kind = CLS_NAN;
		end else if (ax < ay) begin
			cls.kind = CLS_PASS;
		end else if (ax == ay) begin
			cls.kind = CLS_ZERO;
		end else begin
			cls.kind = CLS_WORK;
		end
		cls.ex = (bx == 11'd0) ? EXP_W'(1) : EXP_W'({2'b00, bx});
		cls.ey = (by == 11'd0) ? EXP_W'(1) : EXP_W'({2'b00, by});
		cls.mx = {1'b0, (bx != 11'd0), dividend_bits[51:0]};
		cls.my = {1'b0, (by != 11'd0), divisor_bits[51:0]};
	end

endmodule

FILE: hdl/dfm_unit.sv
// Shared shift / compare-subtract unit used by the sequencer's unpack, divide, normalize and denormalize steps.
module dfm_unit import dfm_pkg::*; (
	input  unit_op_t         op,
	input  logic [MAG_W-1:0] a,
	input  logic [MAG_W-1:0] b,
	output logic [MAG_W-1:0] y,
	output unit_flags_t      flags
);

	logic [MAG_W-1:0] diff;
	logic [MAG_W-1:0] red;

	assign diff     = a - b;
	assign flags.ge = (a >= b);
	assign flags.eq = (a == b);
	assign red      = flags.ge ? diff : a;

	always_comb begin
		case (op)
			OP_SHL:    y = {a[MAG_W-2:0], 1'b0};
			OP_SHR:    y = {1'b0, a[MAG_W-1:1]};
			OP_RED:    y = red;
			OP_REDSHL: y = {red[MAG_W-2:0], 1'b0};
			default:   y = a;
		endcase
	end

endmodule

FILE: hdl/dfm_seq.sv
// Sequencer: special-case results, or unpack, shift-subtract loop, renormalize and pack the remainder.
module dfm_seq import dfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cls_t        cls,
	input  logic [63:0] dividend_bits,
	output logic        idle,
	output logic        res_valid,
	input  logic        res_take,
	output logic [63:0] res_bits
);

	seq_state_t state_q, state_d;

	logic                    sx_q;
	logic signed [EXP_W-1:0] ex_q, ex_d;
	logic signed [EXP_W-1:0] ey_q, ey_d;
	logic [MAG_W-1:0]        mx_q, mx_d;
	logic [MAG_W-1:0]        my_q, my_d;
	logic [63:0]             res_q, res_d;

	unit_op_t         u_op;
	logic [MAG_W-1:0] u_a;
	logic [MAG_W-1:0] u_y;
	unit_flags_t      u_flags;
	logic [63:0]      packed_res;

	dfm_unit u_unit (
		.op    (u_op),
		.a     (u_a),
		.b     (my_q),
		.y     (u_y),
		.flags (u_flags)
	);

	assign packed_res = {sx_q, (mx_q[52] ? ex_q[10:0] : 11'd0), mx_q[51:0]};

	always_comb begin
		state_d = state_q;
		ex_d    = ex_q;
		ey_d    = ey_q;
		mx_d    = mx_q;
		my_d    = my_q;
		res_d   = res_q;
		u_op    = OP_SHL;
		u_a     = mx_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ex_d = cls.ex;
					ey_d = cls.ey;
					mx_d = cls.mx;
					my_d = cls.my;
					case (cls.kind)
						CLS_NAN: begin
							res_d   = QNAN_BITS;
							state_d = S_DONE;
						end
						CLS_PASS: begin
							res_d   = dividend_bits;
							state_d = S_DONE;
						end
						CLS_ZERO: begin
							res_d   = {cls.sign, 63'd0};
							state_d = S_DONE;
						end
						default: state_d = S_UNPX;
					endcase
				end
			end
			S_UNPX: begin
				if (mx_q[52]) begin
					state_d = S_UNPY;
				end else begin
					mx_d = u_y;
					ex_d = ex_q - EXP_W'(1);
				end
			end
			S_UNPY: begin
				u_a = my_q;
				if (my_q[52]) begin
					state_d = S_DIV;
				end else begin
					my_d = u_y;
					ey_d = ey_q - EXP_W'(1);
				end
			end
			S_DIV: begin
				u_op = (ex_q > ey_q) ? OP_REDSHL : OP_RED;
				if (u_flags.ge && u_flags.eq) begin
					res_d   = {sx_q, 63'd0};
					state_d = S_DONE;
				end else begin
					mx_d = u_y;
					if (ex_q > ey_q) begin
						ex_d = ex_q - EXP_W'(1);
					end else begin
						state_d = S_NORM;
					end
				end
			end
			S_NORM: begin
				if (!mx_q[52]) begin
					mx_d = u_y;
					ex_d = ex_q - EXP_W'(1);
				end else if (ex_q < EXP_W'(1)) begin
					state_d = S_DENORM;
				end else begin
					res_d   = packed_res;
					state_d = S_DONE;
				end
			end
			S_DENORM: begin
				u_op = OP_SHR;
				if (ex_q < EXP_W'(1)) begin
					mx_d = u_y;
					ex_d = ex_q + EXP_W'(1);
				end else begin
					res_d   = packed_res;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sx_q <= cls.sign;
		end
		ex_q  <= ex_d;
		ey_q  <= ey_d;
		mx_q  <= mx_d;
		my_q  <= my_d;
		res_q <= res_d;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_bits  = res_q;

endmodule

FILE: hdl/double_fmod_remainder_unit.sv
// Top level of the double-precision fmod unit with its output register.
//
// Usage:
//   Input channel: in_valid/in_ready with dividend_bits and divisor_bits, the
//   raw binary64 encodings of x and y. Output channel: out_valid/out_ready
//   with remainder_bits, the binary64 encoding of fmod(x, y).
//   One beat is worked on at a time; in_ready is high only while the
//   sequencer is idle, so the next input beat is taken at the earliest on
//   the edge at which the previous output beat can leave.
//   From input beat to output beat: special cases (NaN, |x| <= |y|) are
//   decided on acceptance. Otherwise the sequencer shifts out the leading
//   zeros of subnormal operands (lzx, lzy), works off the exponent gap
//   ex - ey (one shift-subtract per cycle in the shared unit, at most about
//   2100), renormalizes the remainder by left shifts (lzr) and, for a
//   subnormal result, shifts it right (dn) before it is packed.
//   Reset clears the sequencer to idle and drops any held output beat.
//   When the receiver stalls, the finished result waits in the output
//   register; the sequencer can finish one more item and hold it, and
//   in_ready stays low until that result has moved to the output register.
module double_fmod_remainder_unit import dfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] dividend_bits,
	input  logic [63:0] divisor_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] remainder_bits
);

	cls_t        cls;
	logic        idle;
	logic        res_valid;
	logic        res_take;
	logic [63:0] res_bits;
	logic        out_valid_q;
	logic [63:0] out_bits_q;

	dfm_classify u_classify (
		.dividend_bits (dividend_bits),
		.divisor_bits  (divisor_bits),
		.cls           (cls)
	);

	dfm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && in_ready),
		.cls           (cls),
		.dividend_bits (dividend_bits),
		.idle          (idle),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res_bits      (res_bits)
	);

	assign in_ready = idle;
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_bits_q <= res_bits;
		end
	end

	assign out_valid      = out_valid_q;
	assign remainder_bits = out_bits_q;

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("sequencer idle while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again while an item is in work");

	a_take_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> (out_valid && remainder_bits == $past(res_bits)))
		else $error("finished result not loaded into the output register");

	a_take_frees_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> in_ready)
		else $error("sequencer not idle after handing on its result");

endmodule
